[hw/rtl/rgbs_pkg.sv]
package rgbs_pkg;

    // Frame store geometry (both sizes are powers of two)
    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int COL_IDX_W      = $clog2(MAX_SRC_WIDTH);
    localparam int ROW_IDX_W      = $clog2(MAX_SRC_HEIGHT);
    localparam int ADDR_W         = COL_IDX_W + ROW_IDX_W;
    localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int CHAN_W         = 8;
    localparam int NUM_CHAN       = 3;
    localparam int PIX_W          = NUM_CHAN * CHAN_W;

    // Field and register widths
    localparam int COORD_W    = 10;
    localparam int SRC_SIZE_W = 9;
    localparam int DST_SIZE_W = 11;
    localparam int SCALE_W    = 25;
    localparam int FRAC_BITS  = 16;

    // Arithmetic widths
    localparam int PROD_W = COORD_W + SCALE_W;
    localparam int INT_W  = PROD_W - FRAC_BITS;
    localparam int OMF_W  = FRAC_BITS + 1;
    localparam int WGT_W  = 2 * FRAC_BITS + 1;
    localparam int ACC_W  = 2 * FRAC_BITS + CHAN_W;
    localparam logic [OMF_W-1:0]   ONE_FX  = OMF_W'(1) << FRAC_BITS;
    localparam logic [WGT_W+1:0]   WGT_SUM = (WGT_W + 2)'(1) << (2 * FRAC_BITS);

    // Stream and configuration port widths
    localparam int IN_DATA_W  = 8 * ((2 * COORD_W + PIX_W + 7) / 8);
    localparam int OUT_DATA_W = 8 * ((PIX_W + 7) / 8);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SCALE_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOR_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VERT_SCALE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 3'd6;

    // Item kinds and filter modes
    localparam logic MODE_LOAD      = 1'b0;
    localparam logic MODE_REQUEST   = 1'b1;
    localparam logic FILTER_NEAREST = 1'b0;
    localparam logic FILTER_BILIN   = 1'b1;

    // Neighbour read order
    localparam logic [1:0] NB_X0Y0 = 2'd0;
    localparam logic [1:0] NB_X1Y0 = 2'd1;
    localparam logic [1:0] NB_X0Y1 = 2'd2;
    localparam logic [1:0] NB_X1Y1 = 2'd3;

    typedef struct packed {
        logic       take;
        logic       mult;
        logic       index;
        logic       rd;
        logic [1:0] rd_sel;
        logic       mac;
        logic       mac_first;
        logic [1:0] mac_sel;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic in_req;
        logic in_err;
        logic out_space;
    } sts_t;

endpackage

[hw/rtl/rgbs_ram.sv]
module rgbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/rgbs_ctrl.sv]
module rgbs_ctrl
    import rgbs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MULT  = 6'b000010,
        ST_INDEX = 6'b000100,
        ST_READ  = 6'b001000,
        ST_LAST  = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take = 1'b1;
                    if (sts.in_req)
                    begin
                        state_next = sts.in_err ? ST_EMIT : ST_MULT;
                    end
                end
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_INDEX;
            end
            ST_INDEX:
            begin
                cmd.index  = 1'b1;
                cnt_next   = NB_X0Y0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                // issue one neighbour read, accumulate the one fetched last cycle
                cmd.rd        = 1'b1;
                cmd.rd_sel    = cnt_reg;
                cmd.mac       = (cnt_reg != NB_X0Y0);
                cmd.mac_first = (cnt_reg == NB_X1Y0);
                cmd.mac_sel   = cnt_reg - 2'd1;
                cnt_next      = cnt_reg + 2'd1;
                if (cnt_reg == NB_X1Y1)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                cmd.mac     = 1'b1;
                cmd.mac_sel = NB_X1Y1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_space)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_index_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INDEX) |=> (state_reg == ST_READ && cnt_reg == NB_X0Y0))
        else $error("read sequence did not start at the first neighbour");

    a_four_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAST) |-> ($past(state_reg) == ST_READ && $past(cnt_reg) == NB_X1Y1))
        else $error("final accumulate reached without four reads");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && !sts.in_req) |=> (state_reg == ST_IDLE))
        else $error("load transfer left the idle state");

endmodule

[hw/rtl/rgbs_dp.sv]
module rgbs_dp
    import rgbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    function automatic logic [SRC_SIZE_W-1:0] clamp_idx(
        input logic [INT_W:0]          v,
        input logic [SRC_SIZE_W-1:0]   size
    );
        logic [SRC_SIZE_W-1:0] res;
        if (v >= (INT_W + 1)'(size))
        begin
            res = size - SRC_SIZE_W'(1);
        end
        else
        begin
            res = v[SRC_SIZE_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [SRC_SIZE_W-1:0] eff_size(
        input logic [SRC_SIZE_W-1:0] r,
        input logic [SRC_SIZE_W-1:0] maxv
    );
        logic [SRC_SIZE_W-1:0] res;
        if (r == '0)
        begin
            res = SRC_SIZE_W'(1);
        end
        else if (r > maxv)
        begin
            res = maxv;
        end
        else
        begin
            res = r;
        end
        return res;
    endfunction

    // Configuration registers
    logic [SRC_SIZE_W-1:0] src_width_reg, src_height_reg;
    logic [DST_SIZE_W-1:0] dst_width_reg, dst_height_reg;
    logic [SCALE_W-1:0]    hor_scale_reg, vert_scale_reg;
    logic                  filter_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg   <= SRC_SIZE_W'(256);
            src_height_reg  <= SRC_SIZE_W'(256);
            dst_width_reg   <= DST_SIZE_W'(256);
            dst_height_reg  <= DST_SIZE_W'(256);
            hor_scale_reg   <= SCALE_W'(1) << FRAC_BITS;
            vert_scale_reg  <= SCALE_W'(1) << FRAC_BITS;
            filter_mode_reg <= FILTER_BILIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC_WIDTH:   src_width_reg   <= cfg_data[SRC_SIZE_W-1:0];
                CFG_SRC_HEIGHT:  src_height_reg  <= cfg_data[SRC_SIZE_W-1:0];
                CFG_DST_WIDTH:   dst_width_reg   <= cfg_data[DST_SIZE_W-1:0];
                CFG_DST_HEIGHT:  dst_height_reg  <= cfg_data[DST_SIZE_W-1:0];
                CFG_HOR_SCALE:   hor_scale_reg   <= cfg_data[SCALE_W-1:0];
                CFG_VERT_SCALE:  vert_scale_reg  <= cfg_data[SCALE_W-1:0];
                CFG_FILTER_MODE: filter_mode_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Input fields
    logic [COORD_W-1:0] in_col, in_row;
    logic [PIX_W-1:0]   in_pix;

    assign in_col = s_tdata[COORD_W-1:0];
    assign in_row = s_tdata[2*COORD_W-1:COORD_W];
    // stored as red, green, blue from the top down
    assign in_pix = {s_tdata[2*COORD_W+CHAN_W-1:2*COORD_W],
                     s_tdata[2*COORD_W+2*CHAN_W-1:2*COORD_W+CHAN_W],
                     s_tdata[2*COORD_W+3*CHAN_W-1:2*COORD_W+2*CHAN_W]};

    assign sts.in_req = (s_tuser == MODE_REQUEST);
    assign sts.in_err = ((DST_SIZE_W)'(in_col) >= dst_width_reg)
                     || ((DST_SIZE_W)'(in_row) >= dst_height_reg);

    // Item registers
    logic [COORD_W-1:0] col_reg, row_reg;
    logic               err_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            col_reg <= in_col;
            row_reg <= in_row;
            err_reg <= sts.in_err;
        end
    end

    // Position products: i * scale for bilinear, (i - 1) * scale for nearest
    logic [PROD_W-1:0]  prod_x_reg, prod_y_reg;
    logic [COORD_W-1:0] op_x, op_y;

    assign op_x = (filter_mode_reg == FILTER_BILIN) ? col_reg : col_reg - COORD_W'(1);
    assign op_y = (filter_mode_reg == FILTER_BILIN) ? row_reg : row_reg - COORD_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            prod_x_reg <= PROD_W'(op_x * hor_scale_reg);
            prod_y_reg <= PROD_W'(op_y * vert_scale_reg);
        end
    end

    // Neighbour indexes and weights
    logic [SRC_SIZE_W-1:0] w_eff, h_eff;
    logic [INT_W-1:0]      xb, yb;
    logic [SRC_SIZE_W-1:0] x_lin0, x_lin1, y_lin0, y_lin1, x_near, y_near;
    logic [FRAC_BITS-1:0]  fx, fy;
    logic [OMF_W-1:0]      omfx, omfy;
    logic [COL_IDX_W-1:0]  x0_reg, x1_reg;
    logic [ROW_IDX_W-1:0]  y0_reg, y1_reg;
    logic [WGT_W-1:0]      wgt_reg [4];

    assign w_eff = eff_size(src_width_reg, SRC_SIZE_W'(MAX_SRC_WIDTH));
    assign h_eff = eff_size(src_height_reg, SRC_SIZE_W'(MAX_SRC_HEIGHT));
    assign xb    = prod_x_reg[PROD_W-1:FRAC_BITS];
    assign yb    = prod_y_reg[PROD_W-1:FRAC_BITS];

    always_comb
    begin
        x_lin0 = clamp_idx({1'b0, xb}, w_eff);
        x_lin1 = clamp_idx((INT_W + 1)'(x_lin0) + (INT_W + 1)'(1), w_eff);
        y_lin0 = clamp_idx({1'b0, yb}, h_eff);
        y_lin1 = clamp_idx((INT_W + 1)'(y_lin0) + (INT_W + 1)'(1), h_eff);

        // column zero: index 1 - ceil(scale), non-positive unless the scale is zero
        if (col_reg == '0)
        begin
            x_near = (hor_scale_reg != '0) ? '0 : clamp_idx((INT_W + 1)'(1), w_eff);
        end
        else
        begin
            x_near = clamp_idx({1'b0, xb} + (INT_W + 1)'(1), w_eff);
        end
        if (row_reg == '0)
        begin
            y_near = (vert_scale_reg != '0) ? '0 : clamp_idx((INT_W + 1)'(1), h_eff);
        end
        else
        begin
            y_near = clamp_idx({1'b0, yb} + (INT_W + 1)'(1), h_eff);
        end

        // nearest reuses the weighted path with all weight on one neighbour
        fx   = (filter_mode_reg == FILTER_BILIN) ? prod_x_reg[FRAC_BITS-1:0] : '0;
        fy   = (filter_mode_reg == FILTER_BILIN) ? prod_y_reg[FRAC_BITS-1:0] : '0;
        omfx = ONE_FX - OMF_W'(fx);
        omfy = ONE_FX - OMF_W'(fy);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.index)
        begin
            if (filter_mode_reg == FILTER_BILIN)
            begin
                x0_reg <= x_lin0[COL_IDX_W-1:0];
                x1_reg <= x_lin1[COL_IDX_W-1:0];
                y0_reg <= y_lin0[ROW_IDX_W-1:0];
                y1_reg <= y_lin1[ROW_IDX_W-1:0];
            end
            else
            begin
                x0_reg <= x_near[COL_IDX_W-1:0];
                x1_reg <= x_near[COL_IDX_W-1:0];
                y0_reg <= y_near[ROW_IDX_W-1:0];
                y1_reg <= y_near[ROW_IDX_W-1:0];
            end
            wgt_reg[NB_X0Y0] <= WGT_W'(omfy * omfx);
            wgt_reg[NB_X1Y0] <= WGT_W'(omfy * OMF_W'(fx));
            wgt_reg[NB_X0Y1] <= WGT_W'(OMF_W'(fy) * omfx);
            wgt_reg[NB_X1Y1] <= WGT_W'(OMF_W'(fy) * OMF_W'(fx));
        end
    end

    // Frame store
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [PIX_W-1:0]     ram_rdata;
    logic [COL_IDX_W-1:0] rd_x;
    logic [ROW_IDX_W-1:0] rd_y;

    // drop loads that fall outside the store
    assign ram_we = cmd.take && (s_tuser == MODE_LOAD)
                 && (in_col < COORD_W'(MAX_SRC_WIDTH))
                 && (in_row < COORD_W'(MAX_SRC_HEIGHT));

    always_comb
    begin
        case (cmd.rd_sel)
            NB_X0Y0:
            begin
                rd_x = x0_reg;
                rd_y = y0_reg;
            end
            NB_X1Y0:
            begin
                rd_x = x1_reg;
                rd_y = y0_reg;
            end
            NB_X0Y1:
            begin
                rd_x = x0_reg;
                rd_y = y1_reg;
            end
            NB_X1Y1:
            begin
                rd_x = x1_reg;
                rd_y = y1_reg;
            end
            default:
            begin
                rd_x = x0_reg;
                rd_y = y0_reg;
            end
        endcase
        if (ram_we)
        begin
            ram_addr = {in_row[ROW_IDX_W-1:0], in_col[COL_IDX_W-1:0]};
        end
        else
        begin
            ram_addr = {rd_y, rd_x};
        end
    end

    rgbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_pix),
        .rdata (ram_rdata)
    );

    // Weighted accumulate, channel 0 is red
    logic [ACC_W-1:0] acc_reg [NUM_CHAN];
    logic [WGT_W-1:0] wgt_sel;
    logic [ACC_W-1:0] term [NUM_CHAN];

    assign wgt_sel = wgt_reg[cmd.mac_sel];

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            term[c] = ACC_W'(wgt_sel * ram_rdata[PIX_W-1-CHAN_W*c -: CHAN_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                acc_reg[c] <= cmd.mac_first ? term[c] : acc_reg[c] + term[c];
            end
        end
    end

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_err_reg;

    assign sts.out_space = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_err_reg <= err_reg;
            if (err_reg)
            begin
                out_data_reg <= '0;
            end
            else
            begin
                out_data_reg <= OUT_DATA_W'({acc_reg[2][ACC_W-1 -: CHAN_W],
                                             acc_reg[1][ACC_W-1 -: CHAN_W],
                                             acc_reg[0][ACC_W-1 -: CHAN_W]});
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.index |=> (((WGT_W + 2)'(wgt_reg[0]) + (WGT_W + 2)'(wgt_reg[1])
                      + (WGT_W + 2)'(wgt_reg[2]) + (WGT_W + 2)'(wgt_reg[3])) == WGT_SUM))
        else $error("neighbour weights do not sum to one");

endmodule

[hw/rtl/rgb_image_scaler.sv]
// RGB888 image scaler with an on-chip 256 x 256 frame store. An input transfer with
// s_tuser low loads one source pixel at (column, row) and gives no result; loads
// outside the store are dropped. A transfer with s_tuser high requests one destination
// pixel and gives exactly one result: its colour by nearest or bilinear filtering, or
// req_error with zero colour if the pixel lies outside the destination size. Pixels
// must be loaded before they are read; the store holds no defined value after reset.
// Registers are written through cfg_we/cfg_index/cfg_data while no item is in flight.
// A load needs only its transfer. An in-range request occupies the block from its
// transfer through each of its steps in order: the transfer, one multiply, one index
// and weight step, four reads of the single-port frame store (one neighbour each), one
// final accumulate step and one output step; an out-of-range request has only the
// transfer and the output step. The output step waits while the output register still
// holds a result that has not been taken. The output register holds a finished result
// while the next item is taken.
module rgb_image_scaler
    import rgbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // column [9:0], row [19:10], red_in [27:20], green_in [35:28], blue_in [43:36]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // mode [0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // red [7:0], green [15:8], blue [23:16]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // req_error [0]
    output logic                  m_tuser
);

    cmd_t cmd;
    sts_t sts;

    rgbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rgbs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
